// ----- rtl/round_robin_task_scheduler_core_defines.svh -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler assertion macros
// Shared macros for the concurrent assertions of the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Opcodes, slot states, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_EXIT   = 3'd1;
   localparam logic [2:0] OP_YIELD  = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;

   localparam logic [1:0] ST_UNUSED  = 2'd0;
   localparam logic [1:0] ST_READY   = 2'd1;
   localparam logic [1:0] ST_RUNNING = 2'd2;
   localparam logic [1:0] ST_DEAD    = 2'd3;

   localparam logic [1:0] STS_DONE      = 2'd0;
   localparam logic [1:0] STS_NO_SLOT   = 2'd1;
   localparam logic [1:0] STS_IGNORED   = 2'd2;
   localparam logic [1:0] STS_NOT_FOUND = 2'd3;

   localparam logic [7:0] SLICE_RESET = 8'd10;

   typedef struct packed {
      logic [31:0] pid;
      logic [7:0]  slice;
      logic [31:0] ticks;
   } rrts_rec_type;

   typedef struct packed {
      logic       capture;
      logic       idx_inc;
      logic       kill;
      logic       enq;
      logic       create;
      logic       tick_wr;
      logic       pick;
      logic       set_status;
      logic [1:0] status;
      logic       set_lookup;
      logic       rsp_load;
   } rrts_cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       cur_valid;
      logic       cur_zero;
      logic [1:0] st_rd;
      logic       idx_last;
      logic       lk_match;
      logic       tick_expire;
      logic       rsp_full;
   } rrts_stat_type;

endpackage

// ----- rtl/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler controller
// Sequences each request through slot scans, table updates and scheduling.
// ----------------------------------------------------------------------------
module rrts_ctrl import rrts_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rrts_stat_type stat,
   output rrts_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN, S_CREATE, S_TICK_WR, S_LK_RD, S_LK_CHK,
      S_SCHED_RD, S_SCHED_PICK, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.opcode)
               OP_CREATE: state_in = S_SCAN;
               OP_EXIT: begin
                  if (!stat.cur_valid || stat.cur_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STS_IGNORED;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.kill = 1'b1;
                     state_in = S_SCHED_RD;
                  end
               end
               OP_YIELD: begin
                  cmd.enq  = stat.cur_valid && (stat.st_rd == ST_RUNNING);
                  state_in = S_SCHED_RD;
               end
               OP_TICK: begin
                  if (!stat.cur_valid) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = STS_IGNORED;
                     state_in       = S_FINISH;
                  end else begin
                     state_in = S_TICK_WR;
                  end
               end
               OP_LOOKUP: state_in = S_LK_CHK;
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = STS_IGNORED;
                  state_in       = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            priority if (stat.st_rd == ST_UNUSED) begin
               state_in = S_CREATE;
            end else if (stat.idx_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = STS_NO_SLOT;
               state_in       = S_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_CREATE: begin
            cmd.create = 1'b1;
            state_in   = S_FINISH;
         end
         S_TICK_WR: begin
            cmd.tick_wr = 1'b1;
            state_in    = stat.tick_expire ? S_SCHED_RD : S_FINISH;
         end
         S_LK_RD: state_in = S_LK_CHK;
         S_LK_CHK: begin
            priority if (stat.lk_match) begin
               cmd.set_lookup = 1'b1;
               state_in       = S_FINISH;
            end else if (stat.idx_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = STS_NOT_FOUND;
               state_in       = S_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_LK_RD;
            end
         end
         S_SCHED_RD: state_in = S_SCHED_PICK;
         S_SCHED_PICK: begin
            cmd.pick = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_full) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rrts_datapath.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler datapath
// Slot table, ready queue, current task, pid counter and result registers.
// ----------------------------------------------------------------------------
module rrts_datapath import rrts_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  rrts_cmd_type  cmd,
   output rrts_stat_type stat,
   input  logic [2:0]    req_opcode,
   input  logic [31:0]   req_lookup_pid,
   input  logic          csr_valid,
   input  logic [7:0]    csr_wdata,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [31:0]   rsp_result_pid,
   output logic [3:0]    rsp_result_slot,
   output logic [1:0]    rsp_found_state,
   output logic [31:0]   rsp_found_ticks,
   output logic          rsp_switched,
   output logic          rsp_prev_valid,
   output logic [3:0]    rsp_prev_slot,
   output logic [3:0]    rsp_next_slot
);

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SLOT_COUNT);
   localparam logic [SW:0] WRAP = (SW+1)'(SLOT_COUNT);

   function automatic logic [3:0] low4(input logic [SW-1:0] s);
      logic [8:0] w;
      w = 9'(s);
      return w[3:0];
   endfunction

   logic [1:0]    state_ff [SLOT_COUNT];
   rrts_rec_type  rec_mem [SLOT_COUNT];
   logic [SW-1:0] fifo_mem [SLOT_COUNT];

   logic [SW-1:0] head_ff, cur_ff, idx_ff, fifo_q_ff;
   logic [CW-1:0] count_ff;
   logic          cur_valid_ff, slot0_wr_ff, rec_zero_ff, rsp_valid_ff;
   logic [31:0]   next_pid_ff, pid_ff;
   logic [7:0]    slice_len_ff;
   logic [2:0]    op_ff;
   rrts_rec_type  rec_q_ff;

   logic [1:0]    res_status_ff, res_found_state_ff;
   logic [31:0]   res_pid_ff, res_ticks_ff;
   logic [3:0]    res_slot_ff, res_prev_slot_ff, res_next_slot_ff;
   logic          res_switched_ff, res_prev_valid_ff;

   logic [SW-1:0] rd_slot, rec_addr, enq_slot, tail, nxt, head_in;
   logic [SW:0]   tail_sum;
   logic [1:0]    st_rd;
   rrts_rec_type  rec, tick_rec, rec_wdata;
   logic [7:0]    slice_dec;
   logic          expire, enq_now, rec_we, same;

   always_comb begin
      rd_slot   = (op_ff == OP_YIELD) ? cur_ff : idx_ff;
      rec_addr  = (op_ff == OP_TICK) ? cur_ff : idx_ff;
      enq_slot  = (op_ff == OP_CREATE) ? idx_ff : cur_ff;
      st_rd     = state_ff[rd_slot];
      rec       = rec_zero_ff ? '0 : rec_q_ff;
      slice_dec = (rec.slice != 8'd0) ? rec.slice - 8'd1 : 8'd0;
      expire    = (slice_dec == 8'd0);
      tick_rec.pid   = rec.pid;
      tick_rec.slice = expire ? slice_len_ff : slice_dec;
      tick_rec.ticks = rec.ticks + 32'd1;
      enq_now   = cmd.create || cmd.enq || (cmd.tick_wr && expire && (cur_ff != '0));
      rec_we    = cmd.create || cmd.tick_wr;
      rec_wdata = cmd.create ? rrts_rec_type'{next_pid_ff, slice_len_ff, 32'd0} : tick_rec;
      tail_sum  = (SW+1)'(head_ff) + (SW+1)'(count_ff);
      tail      = (tail_sum >= WRAP) ? SW'(tail_sum - WRAP) : tail_sum[SW-1:0];
      nxt       = (count_ff != '0) ? fifo_q_ff : '0;
      head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      same      = cur_valid_ff && (nxt == cur_ff);
   end

   assign stat.opcode      = op_ff;
   assign stat.cur_valid   = cur_valid_ff;
   assign stat.cur_zero    = (cur_ff == '0);
   assign stat.st_rd       = st_rd;
   assign stat.idx_last    = (idx_ff == LAST_SLOT);
   assign stat.lk_match    = (st_rd != ST_UNUSED) && (rec.pid == pid_ff);
   assign stat.tick_expire = expire;
   assign stat.rsp_full    = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            state_ff[i] <= (i == 0) ? ST_READY : ST_UNUSED;
         end
         head_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         next_pid_ff  <= 32'd1;
         slice_len_ff <= SLICE_RESET;
         slot0_wr_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            slice_len_ff <= csr_wdata;
         end
         if (enq_now) begin
            state_ff[enq_slot] <= ST_READY;
            if (count_ff != FULL_COUNT) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (cmd.kill) begin
            state_ff[cur_ff] <= ST_DEAD;
         end
         if (cmd.pick) begin
            state_ff[nxt] <= ST_RUNNING;
            if (count_ff != '0) begin
               head_ff  <= head_in;
               count_ff <= count_ff - 1'b1;
            end
            if (!same) begin
               cur_ff       <= nxt;
               cur_valid_ff <= 1'b1;
            end
         end
         if (cmd.create) begin
            next_pid_ff <= next_pid_ff + 32'd1;
         end
         if (rec_we && (rec_addr == '0)) begin
            slot0_wr_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_q_ff    <= rec_mem[rec_addr];
      rec_zero_ff <= (rec_addr == '0) && !slot0_wr_ff;
      fifo_q_ff   <= fifo_mem[head_ff];
      if (rec_we) begin
         rec_mem[rec_addr] <= rec_wdata;
      end
      if (enq_now && (count_ff != FULL_COUNT)) begin
         fifo_mem[tail] <= enq_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff              <= req_opcode;
         pid_ff             <= req_lookup_pid;
         idx_ff             <= '0;
         res_status_ff      <= STS_DONE;
         res_pid_ff         <= '0;
         res_slot_ff        <= '0;
         res_found_state_ff <= '0;
         res_ticks_ff       <= '0;
         res_switched_ff    <= 1'b0;
         res_prev_valid_ff  <= 1'b0;
         res_prev_slot_ff   <= '0;
         res_next_slot_ff   <= '0;
      end
      if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.create) begin
         res_pid_ff  <= next_pid_ff;
         res_slot_ff <= low4(idx_ff);
      end
      if (cmd.set_lookup) begin
         res_pid_ff         <= rec.pid;
         res_slot_ff        <= low4(idx_ff);
         res_found_state_ff <= st_rd;
         res_ticks_ff       <= rec.ticks;
      end
      if (cmd.pick && !same) begin
         res_switched_ff   <= 1'b1;
         res_prev_valid_ff <= cur_valid_ff;
         res_prev_slot_ff  <= cur_valid_ff ? low4(cur_ff) : 4'd0;
         res_next_slot_ff  <= low4(nxt);
      end
      if (cmd.rsp_load) begin
         rsp_status      <= res_status_ff;
         rsp_result_pid  <= res_pid_ff;
         rsp_result_slot <= res_slot_ff;
         rsp_found_state <= res_found_state_ff;
         rsp_found_ticks <= res_ticks_ff;
         rsp_switched    <= res_switched_ff;
         rsp_prev_valid  <= res_prev_valid_ff;
         rsp_prev_slot   <= res_prev_slot_ff;
         rsp_next_slot   <= res_next_slot_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/round_robin_task_scheduler_core.sv -----
// Ignored requests go straight to the finish state; tick writes the record and, when the
// slice ends, schedules; exit and yield schedule; create and lookup scan the slots in order.
// One request at a time; the slot scan of the single-port table sets the rate.
// A finished beat waits in the response register while the next request is taken.
// Reset is synchronous: slot 0 holds the idle task, the queue is empty, slice is 10.
// ----------------------------------------------------------------------------
// Round-robin task scheduler core
// Time-slice task scheduler over a fixed slot table with a FIFO ready queue.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core import rrts_pkg::*; #(
   parameter int SLOT_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_lookup_pid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_result_pid,
   output logic [3:0]  rsp_result_slot,
   output logic [1:0]  rsp_found_state,
   output logic [31:0] rsp_found_ticks,
   output logic        rsp_switched,
   output logic        rsp_prev_valid,
   output logic [3:0]  rsp_prev_slot,
   output logic [3:0]  rsp_next_slot,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);

   rrts_cmd_type  cmd;
   rrts_stat_type stat;

   assign csr_ready = 1'b1;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrts_datapath #(.SLOT_COUNT(SLOT_COUNT)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_lookup_pid  (req_lookup_pid),
      .csr_valid       (csr_valid),
      .csr_wdata       (csr_wdata),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_result_pid  (rsp_result_pid),
      .rsp_result_slot (rsp_result_slot),
      .rsp_found_state (rsp_found_state),
      .rsp_found_ticks (rsp_found_ticks),
      .rsp_switched    (rsp_switched),
      .rsp_prev_valid  (rsp_prev_valid),
      .rsp_prev_slot   (rsp_prev_slot),
      .rsp_next_slot   (rsp_next_slot)
   );

endmodule

// ----- rtl/rrts_checker.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler checker
// Port-level assertions on the scheduler core, attached by bind.
// ----------------------------------------------------------------------------
`include "round_robin_task_scheduler_core_defines.svh"

module rrts_checker import rrts_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_result_pid,
   input logic [3:0]  rsp_result_slot,
   input logic [1:0]  rsp_found_state,
   input logic [31:0] rsp_found_ticks,
   input logic        rsp_switched,
   input logic        rsp_prev_valid,
   input logic [3:0]  rsp_prev_slot,
   input logic [3:0]  rsp_next_slot
);

   `RRTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_result_pid),
      "response beat changed while stalled")
   `RRTS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready,
      "request taken while another is in flight")
   `RRTS_ASSERT_SAME(a_switch_fields, rsp_valid && !rsp_switched,
      !rsp_prev_valid && (rsp_prev_slot == 4'd0) && (rsp_next_slot == 4'd0),
      "switch fields set without a switch")
   `RRTS_ASSERT_SAME(a_fail_clean, rsp_valid && (rsp_status != STS_DONE),
      !rsp_switched && (rsp_result_pid == 32'd0) && (rsp_found_ticks == 32'd0)
      && (rsp_result_slot == 4'd0) && (rsp_found_state == 2'd0),
      "failed request reports data")

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (.*);

// ----- dv/round_robin_task_scheduler_core_test.sv -----
// ----------------------------------------------------------------------------
// Round-robin task scheduler core testbench
// Drives create, exit, yield, tick and lookup requests through the request
// channel, predicts every response beat with a behavioral scheduler model
// and compares each beat field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core_test;
   import rrts_pkg::*;

   localparam int SLOTS = 16;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] result_pid;
      logic [3:0]  result_slot;
      logic [1:0]  found_state;
      logic [31:0] found_ticks;
      logic        switched;
      logic        prev_valid;
      logic [3:0]  prev_slot;
      logic [3:0]  next_slot;
   } sched_beat_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_opcode = 0;
   logic [31:0] req_lookup_pid = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_result_pid;
   logic [3:0]  rsp_result_slot;
   logic [1:0]  rsp_found_state;
   logic [31:0] rsp_found_ticks;
   logic        rsp_switched;
   logic        rsp_prev_valid;
   logic [3:0]  rsp_prev_slot;
   logic [3:0]  rsp_next_slot;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [7:0]  csr_wdata = 0;

   round_robin_task_scheduler_core DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Scheduler model state.
   logic [1:0]  tbl_state [SLOTS];
   logic [31:0] tbl_pid [SLOTS];
   logic [7:0]  tbl_slice [SLOTS];
   logic [31:0] tbl_ticks [SLOTS];
   logic [3:0]  ready_q [$];
   logic [3:0]  run_slot;
   logic        run_valid;
   logic [31:0] pid_next;
   logic [7:0]  slice_len;

   sched_beat_type pending_beats [$];
   int          errors = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          hold_cycles = 0;
   longint      cycle_count = 0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic void model_reset();
      for (int i = 0; i < SLOTS; i++) begin
         tbl_state[i] = ST_UNUSED;
         tbl_pid[i] = 0;
         tbl_slice[i] = 0;
         tbl_ticks[i] = 0;
      end
      tbl_state[0] = ST_READY;
      ready_q.delete();
      run_slot = 0;
      run_valid = 0;
      pid_next = 1;
      slice_len = SLICE_RESET;
   endfunction

   function automatic void requeue(input logic [3:0] s);
      tbl_state[s] = ST_READY;
      if (ready_q.size() < SLOTS) ready_q.push_back(s);
   endfunction

   function automatic void dispatch(ref sched_beat_type b);
      logic [3:0] nxt;
      nxt = 0;
      if (ready_q.size() > 0) nxt = ready_q.pop_front();
      if (run_valid && nxt == run_slot) begin
         tbl_state[nxt] = ST_RUNNING;
         return;
      end
      b.switched = 1;
      b.prev_valid = run_valid;
      b.prev_slot = run_valid ? run_slot : 4'd0;
      b.next_slot = nxt;
      run_slot = nxt;
      run_valid = 1;
      tbl_state[nxt] = ST_RUNNING;
   endfunction

   function automatic sched_beat_type predict_beat(input logic [2:0] op, input logic [31:0] pid);
      sched_beat_type b;
      int i;
      b = '{default: 0};
      case (op)
         OP_CREATE: begin
            for (i = 0; i < SLOTS; i++) if (tbl_state[i] == ST_UNUSED) break;
            if (i == SLOTS) b.status = STS_NO_SLOT;
            else begin
               tbl_pid[i] = pid_next;
               pid_next++;
               tbl_slice[i] = slice_len;
               tbl_ticks[i] = 0;
               requeue(4'(i));
               b.result_pid = tbl_pid[i];
               b.result_slot = 4'(i);
            end
         end
         OP_EXIT: begin
            if (!run_valid || run_slot == 0) b.status = STS_IGNORED;
            else begin
               tbl_state[run_slot] = ST_DEAD;
               dispatch(b);
            end
         end
         OP_YIELD: begin
            if (run_valid && tbl_state[run_slot] == ST_RUNNING) requeue(run_slot);
            dispatch(b);
         end
         OP_TICK: begin
            if (!run_valid) b.status = STS_IGNORED;
            else begin
               tbl_ticks[run_slot]++;
               if (tbl_slice[run_slot] > 0) tbl_slice[run_slot]--;
               if (tbl_slice[run_slot] == 0) begin
                  tbl_slice[run_slot] = slice_len;
                  if (run_slot != 0) requeue(run_slot);
                  dispatch(b);
               end
            end
         end
         OP_LOOKUP: begin
            for (i = 0; i < SLOTS; i++)
               if (tbl_state[i] != ST_UNUSED && tbl_pid[i] == pid) break;
            if (i == SLOTS) b.status = STS_NOT_FOUND;
            else begin
               b.result_pid = tbl_pid[i];
               b.result_slot = 4'(i);
               b.found_state = tbl_state[i];
               b.found_ticks = tbl_ticks[i];
            end
         end
         default: b.status = STS_IGNORED;
      endcase
      return b;
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [31:0] pid);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_lookup_pid <= pid;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_beats.push_back(predict_beat(op, pid));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_beats.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_slice(input logic [7:0] value);
      drain();
      csr_valid <= 1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      slice_len = value;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("[round_robin_task_scheduler_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 0;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      sched_beat_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            report("unexpected beat", 32'd1, 32'd0);
         end else begin
            w = pending_beats.pop_front();
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
            if (rsp_result_pid !== w.result_pid)
               report("result_pid", rsp_result_pid, w.result_pid);
            if (rsp_result_slot !== w.result_slot)
               report("result_slot", rsp_result_slot, w.result_slot);
            if (rsp_found_state !== w.found_state)
               report("found_state", rsp_found_state, w.found_state);
            if (rsp_found_ticks !== w.found_ticks)
               report("found_ticks", rsp_found_ticks, w.found_ticks);
            if (rsp_switched !== w.switched) report("switched", rsp_switched, w.switched);
            if (rsp_prev_valid !== w.prev_valid)
               report("prev_valid", rsp_prev_valid, w.prev_valid);
            if (rsp_prev_slot !== w.prev_slot) report("prev_slot", rsp_prev_slot, w.prev_slot);
            if (rsp_next_slot !== w.next_slot) report("next_slot", rsp_next_slot, w.next_slot);
         end
      end
   end

   function automatic logic [31:0] pick_pid();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(20);
         default: return tbl_pid[$urandom_range(SLOTS - 1)];
      endcase
   endfunction

   task automatic test_directed();
      send_request(OP_TICK, 0);
      send_request(OP_EXIT, 0);
      send_request(3'd5, 32'hFFFF_FFFF);
      send_request(3'd7, 0);
      send_request(OP_LOOKUP, 0);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
      send_request(OP_YIELD, 0);
      send_request(OP_EXIT, 0);
      send_request(OP_TICK, 0);
      send_request(OP_YIELD, 0);
      repeat (17) send_request(OP_CREATE, 0);
      send_request(OP_YIELD, 0);
      send_request(OP_LOOKUP, 1);
      send_request(OP_LOOKUP, 15);
      send_request(OP_EXIT, 0);
   endtask

   task automatic test_slice_extremes();
      write_slice(8'd0);
      repeat (8) send_request(OP_TICK, 0);
      write_slice(8'd255);
      repeat (6) send_request(OP_TICK, 0);
      send_request(OP_LOOKUP, 2);
      write_slice(8'd1);
   endtask

   task automatic test_random(input int count);
      int r;
      logic [2:0] op;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 14) op = OP_CREATE;
         else if (r < 24) op = OP_EXIT;
         else if (r < 40) op = OP_YIELD;
         else if (r < 75) op = OP_TICK;
         else if (r < 95) op = OP_LOOKUP;
         else op = 3'($urandom_range(7, 5));
         send_request(op, pick_pid());
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      test_random(20);
   endtask

   initial begin
      model_reset();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle = 31;
      recv_idle = 88;
      test_directed();
      test_slice_extremes();
      test_random(250);
      write_slice(8'd3);
      test_random(250);
      send_idle = 88;
      recv_idle = 31;
      test_backpressure();
      write_slice(8'd2);
      test_random(450);
      send_idle = 0;
      recv_idle = 0;
      write_slice(8'($urandom_range(255, 1)));
      test_random(450);
      drain();
      if (errors == 0) $display("[round_robin_task_scheduler_core] OK");
      else $display("[round_robin_task_scheduler_core] ERROR");
      $finish;
   end
endmodule
